// ===== hw/rtl/binary_max_heap_queue_top_defines.svh =====
// Assertion macros used by the heap queue datapath.
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define BMHQ_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must hold in the cycle after a trigger condition.
`define BMHQ_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/bmhq_pkg.sv =====
// Types and constants shared by the heap queue controller, datapath and top level.
package bmhq_pkg;

   localparam int DATA_W      = 32;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_REJECT_FULL,
      CMD_REJECT_EMPTY,
      CMD_BEGIN_INS,
      CMD_BEGIN_EXT,
      CMD_RD_LAST,
      CMD_LOAD_DN,
      CMD_RD_KIDS,
      CMD_CMP_DN,
      CMD_RD_PARENT,
      CMD_CMP_UP,
      CMD_PLACE,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic is_extract;
      logic is_empty;
      logic is_full;
      logic last_one;
      logic pos_zero;
      logic up_move;
      logic dn_move;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/bmhq_ctrl.sv =====
// Controller state machine that sequences inserts, extracts and the sift walks.
module bmhq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bmhq_pkg::dp_status_type st,
   output bmhq_pkg::cmd_type      cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DECIDE  = 9'b000000010,
      ST_UP_RD   = 9'b000000100,
      ST_UP_CMP  = 9'b000001000,
      ST_RD_LAST = 9'b000010000,
      ST_LOAD_DN = 9'b000100000,
      ST_DN_RD   = 9'b001000000,
      ST_DN_CMP  = 9'b010000000,
      ST_EMIT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = bmhq_pkg::CMD_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = bmhq_pkg::CMD_LATCH;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!st.is_extract) begin
               if (st.is_full) begin
                  cmd      = bmhq_pkg::CMD_REJECT_FULL;
                  state_in = ST_EMIT;
               end else begin
                  cmd      = bmhq_pkg::CMD_BEGIN_INS;
                  state_in = ST_UP_RD;
               end
            end else if (st.is_empty) begin
               cmd      = bmhq_pkg::CMD_REJECT_EMPTY;
               state_in = ST_EMIT;
            end else begin
               cmd      = bmhq_pkg::CMD_BEGIN_EXT;
               // Removing the only entry leaves nothing to sift.
               state_in = st.last_one ? ST_EMIT : ST_RD_LAST;
            end
         end
         ST_UP_RD: begin
            if (st.pos_zero) begin
               cmd      = bmhq_pkg::CMD_PLACE;
               state_in = ST_EMIT;
            end else begin
               cmd      = bmhq_pkg::CMD_RD_PARENT;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            cmd      = bmhq_pkg::CMD_CMP_UP;
            state_in = st.up_move ? ST_UP_RD : ST_EMIT;
         end
         ST_RD_LAST: begin
            cmd      = bmhq_pkg::CMD_RD_LAST;
            state_in = ST_LOAD_DN;
         end
         ST_LOAD_DN: begin
            cmd      = bmhq_pkg::CMD_LOAD_DN;
            state_in = ST_DN_CMP;
         end
         ST_DN_RD: begin
            cmd      = bmhq_pkg::CMD_RD_KIDS;
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            cmd      = bmhq_pkg::CMD_CMP_DN;
            state_in = st.dn_move ? ST_DN_RD : ST_EMIT;
         end
         ST_EMIT: begin
            if (st.rsp_free) begin
               cmd      = bmhq_pkg::CMD_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/bmhq_dpath.sv =====
// Datapath: heap memory, entry count, sift position, moving value and result register.
`include "binary_max_heap_queue_top_defines.svh"

module bmhq_dpath #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bmhq_pkg::cmd_type                   cmd,
   output bmhq_pkg::dp_status_type             st,
   input  logic                                req_op,
   input  logic signed [bmhq_pkg::DATA_W-1:0]  req_value,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output logic signed [bmhq_pkg::DATA_W-1:0]  rsp_extracted,
   output logic signed [bmhq_pkg::DATA_W-1:0]  rsp_top,
   output logic [bmhq_pkg::COUNT_OUT_W-1:0]    rsp_count,
   output logic [bmhq_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;

   logic signed [bmhq_pkg::DATA_W-1:0] heap_ff [CAPACITY];
   logic signed [bmhq_pkg::DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic                               op_ff, op_in;
   logic signed [bmhq_pkg::DATA_W-1:0] value_ff, value_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [AW-1:0]                      pos_ff, pos_in;
   logic signed [bmhq_pkg::DATA_W-1:0] hold_ff, hold_in;
   logic signed [bmhq_pkg::DATA_W-1:0] root_ff, root_in;
   logic signed [bmhq_pkg::DATA_W-1:0] res_extracted_ff, res_extracted_in;
   logic [bmhq_pkg::STATUS_W-1:0]      res_status_ff, res_status_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [bmhq_pkg::DATA_W-1:0] rsp_extracted_ff, rsp_extracted_in;
   logic signed [bmhq_pkg::DATA_W-1:0] rsp_top_ff, rsp_top_in;
   logic [CW-1:0]                      rsp_count_ff, rsp_count_in;
   logic [bmhq_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic                               mem_we;
   logic [AW-1:0]                      mem_waddr, addr_a, addr_b;
   logic signed [bmhq_pkg::DATA_W-1:0] mem_wdata;

   logic [IW-1:0]                      left_idx, right_idx, count_wide;
   logic [AW-1:0]                      parent_idx;
   logic                               left_ok, right_ok, left_gt, right_gt;
   logic signed [bmhq_pkg::DATA_W-1:0] best_val;
   logic [CW+bmhq_pkg::COUNT_OUT_W-1:0] count_out_wide;

   assign count_wide = IW'(count_ff);
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = {1'b0, pos_ff, 1'b0} + IW'(2);
   assign parent_idx = (pos_ff - AW'(1)) >> 1;

   // Children past the fill count are ignored; their read data may be stale.
   assign left_ok  = left_idx < count_wide;
   assign right_ok = right_idx < count_wide;
   assign left_gt  = left_ok && (rd_a_ff > hold_ff);
   assign best_val = left_gt ? rd_a_ff : hold_ff;
   assign right_gt = right_ok && (rd_b_ff > best_val);

   assign st.is_extract = (op_ff == bmhq_pkg::OP_EXTRACT);
   assign st.is_empty   = (count_ff == CW'(0));
   assign st.is_full    = (count_ff == CW'(CAPACITY));
   assign st.last_one   = (count_ff == CW'(1));
   assign st.pos_zero   = (pos_ff == AW'(0));
   assign st.up_move    = (hold_ff > rd_a_ff);
   assign st.dn_move    = left_gt || right_gt;
   assign st.rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      op_in            = op_ff;
      value_in         = value_ff;
      count_in         = count_ff;
      pos_in           = pos_ff;
      hold_in          = hold_ff;
      res_extracted_in = res_extracted_ff;
      res_status_in    = res_status_ff;
      rsp_extracted_in = rsp_extracted_ff;
      rsp_top_in       = rsp_top_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      mem_we           = 1'b0;
      mem_waddr        = pos_ff;
      mem_wdata        = hold_ff;
      addr_a           = left_idx[AW-1:0];
      addr_b           = right_idx[AW-1:0];
      unique case (cmd)
         bmhq_pkg::CMD_NONE: begin
         end
         bmhq_pkg::CMD_LATCH: begin
            op_in    = req_op;
            value_in = req_value;
         end
         bmhq_pkg::CMD_REJECT_FULL: begin
            res_status_in    = bmhq_pkg::STATUS_FULL;
            res_extracted_in = '0;
         end
         bmhq_pkg::CMD_REJECT_EMPTY: begin
            res_status_in    = bmhq_pkg::STATUS_EMPTY;
            res_extracted_in = '0;
         end
         bmhq_pkg::CMD_BEGIN_INS: begin
            res_status_in    = bmhq_pkg::STATUS_OK;
            res_extracted_in = '0;
            pos_in           = count_ff[AW-1:0];
            hold_in          = value_ff;
            count_in         = count_ff + CW'(1);
         end
         bmhq_pkg::CMD_BEGIN_EXT: begin
            res_status_in    = bmhq_pkg::STATUS_OK;
            res_extracted_in = root_ff;
            pos_in           = '0;
            count_in         = count_ff - CW'(1);
         end
         bmhq_pkg::CMD_RD_LAST: begin
            addr_a = count_ff[AW-1:0];
         end
         bmhq_pkg::CMD_LOAD_DN: begin
            hold_in = rd_a_ff;
         end
         bmhq_pkg::CMD_RD_KIDS: begin
         end
         bmhq_pkg::CMD_CMP_DN: begin
            mem_we = 1'b1;
            if (right_gt) begin
               mem_wdata = rd_b_ff;
               pos_in    = right_idx[AW-1:0];
            end else if (left_gt) begin
               mem_wdata = rd_a_ff;
               pos_in    = left_idx[AW-1:0];
            end
         end
         bmhq_pkg::CMD_RD_PARENT: begin
            addr_a = parent_idx;
         end
         bmhq_pkg::CMD_CMP_UP: begin
            mem_we = 1'b1;
            // The parent moves down into the hole; ties leave the value here.
            if (st.up_move) begin
               mem_wdata = rd_a_ff;
               pos_in    = parent_idx;
            end
         end
         bmhq_pkg::CMD_PLACE: begin
            mem_we = 1'b1;
         end
         bmhq_pkg::CMD_EMIT: begin
            rsp_valid_in     = 1'b1;
            rsp_extracted_in = res_extracted_ff;
            rsp_top_in       = st.is_empty ? '0 : root_ff;
            rsp_count_in     = count_ff;
            rsp_status_in    = res_status_ff;
         end
         default: begin
         end
      endcase
   end

   // The root is mirrored so the maximum is known without a memory read.
   assign root_in = (mem_we && mem_waddr == AW'(0)) ? mem_wdata : root_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= heap_ff[addr_a];
      rd_b_ff <= heap_ff[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      value_ff         <= value_in;
      pos_ff           <= pos_in;
      hold_ff          <= hold_in;
      root_ff          <= root_in;
      res_extracted_ff <= res_extracted_in;
      res_status_ff    <= res_status_in;
      rsp_extracted_ff <= rsp_extracted_in;
      rsp_top_ff       <= rsp_top_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign count_out_wide = {{bmhq_pkg::COUNT_OUT_W{1'b0}}, rsp_count_ff};

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_extracted = rsp_extracted_ff;
   assign rsp_top       = rsp_top_ff;
   assign rsp_count     = count_out_wide[bmhq_pkg::COUNT_OUT_W-1:0];
   assign rsp_status    = rsp_status_ff;

   `BMHQ_ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "entry count above capacity")
   `BMHQ_ASSERT_CLK(a_write_in_range, clock, reset, mem_we |-> (IW'(pos_ff) < count_wide), "heap write beyond fill count")
   `BMHQ_ASSERT_CLK(a_emit_free, clock, reset, (cmd == bmhq_pkg::CMD_EMIT) |-> st.rsp_free, "result overwritten before its transfer")
   `BMHQ_ASSERT_NEXT(a_full_status, clock, reset, cmd == bmhq_pkg::CMD_REJECT_FULL, count_ff == CW'(CAPACITY), "full status with free slots")

endmodule

// ===== hw/rtl/binary_max_heap_queue_top.sv =====
// Top level of the binary max-heap priority queue.
// A rejected item or the removal of the only entry goes straight to the result; an insert climbs
// one level per compare until it reaches the root or a parent not below it; an extract moves the
// last entry to the root and sinks it until no child is greater.
// One item at a time: the next request is taken only after the previous result is loaded for output.
// Reset empties the queue at once; heap memory contents are not cleared.
module binary_max_heap_queue_top #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] extracted, [63:32] top, [70:64] entry_count
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   bmhq_pkg::cmd_type       cmd;
   bmhq_pkg::dp_status_type st;

   logic signed [bmhq_pkg::DATA_W-1:0] rsp_extracted, rsp_top;
   logic [bmhq_pkg::COUNT_OUT_W-1:0]   rsp_count;
   logic [bmhq_pkg::STATUS_W-1:0]      rsp_status;

   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bmhq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_op        (req_tuser[0]),
      .req_value     (req_tdata),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_extracted (rsp_extracted),
      .rsp_top       (rsp_top),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_top, rsp_extracted};
   assign rsp_tuser = rsp_status;

endmodule

// ===== verif/tb_binary_max_heap_queue_top.sv =====
// Self-checking testbench for the binary max-heap priority queue top level.
`timescale 1ns / 100ps

module tb_binary_max_heap_queue_top;

   localparam int HEAP_DEPTH   = 64;
   localparam int RANDOM_ITEMS = 1930;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int SETTLE_WAIT  = 30;

   typedef struct {
      logic signed [bmhq_pkg::DATA_W-1:0] extracted;
      logic signed [bmhq_pkg::DATA_W-1:0] top;
      logic [bmhq_pkg::COUNT_OUT_W-1:0]   entry_count;
      logic [bmhq_pkg::STATUS_W-1:0]      status;
   } heap_reply_type;

   class heap_scoreboard_type;
      logic signed [bmhq_pkg::DATA_W-1:0] slots [HEAP_DEPTH];
      int                                 fill = 0;
      heap_reply_type                     replies_due [$];
      int                                 errors = 0;

      function void swap_slots(int a, int b);
         logic signed [bmhq_pkg::DATA_W-1:0] t;
         t = slots[a];
         slots[a] = slots[b];
         slots[b] = t;
      endfunction

      // Applies one accepted operation to the shadow heap and queues the reply it must give.
      function void note_heap_op(logic op, logic signed [bmhq_pkg::DATA_W-1:0] value);
         heap_reply_type r;
         int pos, parent, left, right, best;
         r.extracted = '0;
         r.status = bmhq_pkg::STATUS_OK;
         if (op == bmhq_pkg::OP_INSERT) begin
            if (fill >= HEAP_DEPTH) begin
               r.status = bmhq_pkg::STATUS_FULL;
            end else begin
               slots[fill] = value;
               pos = fill;
               fill++;
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (slots[pos] <= slots[parent]) break;
                  swap_slots(pos, parent);
                  pos = parent;
               end
            end
         end else if (fill == 0) begin
            r.status = bmhq_pkg::STATUS_EMPTY;
         end else begin
            r.extracted = slots[0];
            fill--;
            slots[0] = slots[fill];
            pos = 0;
            // The left child wins a tie with the right one; equal parent and child never swap.
            while (1) begin
               left = 2 * pos + 1;
               right = 2 * pos + 2;
               best = pos;
               if (left < fill && slots[left] > slots[pos]) best = left;
               if (right < fill && slots[right] > slots[best]) best = right;
               if (best == pos) break;
               swap_slots(pos, best);
               pos = best;
            end
         end
         r.top = (fill > 0) ? slots[0] : '0;
         r.entry_count = bmhq_pkg::COUNT_OUT_W'(fill);
         replies_due.insert(replies_due.size(), r);
      endfunction

      function void check_reply(logic [71:0] data, logic [bmhq_pkg::STATUS_W-1:0] status);
         heap_reply_type e;
         if (replies_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: extracted %0d top %0d count %0d status %0d",
                        $signed(data[31:0]), $signed(data[63:32]), data[70:64], status);
            return;
         end
         e = replies_due.pop_front();
         if (data[31:0] !== e.extracted || data[63:32] !== e.top ||
             data[70:64] !== e.entry_count || status !== e.status) begin
            errors++;
            if (errors <= 10) begin
               $display("result mismatch: expected extracted %0d top %0d count %0d status %0d",
                        e.extracted, e.top, e.entry_count, e.status);
               $display("                 got extracted %0d top %0d count %0d status %0d",
                        $signed(data[31:0]), $signed(data[63:32]), data[70:64], status);
            end
         end
      endfunction

      function int pending();
         return replies_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic [0:0]  req_tuser = '0;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // [31:0] extracted, [63:32] top, [70:64] entry_count
   logic [1:0]  rsp_tuser;        // [1:0] status

   heap_scoreboard_type sb = new();
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int stall_cycles = 0;

   binary_max_heap_queue_top #(.CAPACITY(HEAP_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Result side: checks each transfer; ready is random unless quiet, with one long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_reply(rsp_tdata, rsp_tuser);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("binary_max_heap_queue_top test failed");
            $finish;
         end
      end
   end

   task automatic send_item(input logic op, input logic signed [bmhq_pkg::DATA_W-1:0] value);
      if (!quiet) begin
         while ($urandom_range(99) < 13) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_heap_op(op, value);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic signed [bmhq_pkg::DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0, 1, 2, 3: return $urandom;
         // A narrow range produces many equal keys and exercises the tie rules.
         4, 5, 6: return $signed($urandom_range(6)) - 3;
         7: begin
            case ($urandom_range(3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         8: return 32'sh7FFF_FFFF - $signed($urandom_range(15));
         default: return 32'sh8000_0000 + $signed($urandom_range(15));
      endcase
   endfunction

   initial begin
      int sent;
      int kind;
      int run_len;
      int insert_pct;
      logic op;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extract from empty, extreme keys, ties on the way up and down.
      send_item(bmhq_pkg::OP_EXTRACT, 32'sd17);
      send_item(bmhq_pkg::OP_INSERT, 32'sd0);
      send_item(bmhq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
      send_item(bmhq_pkg::OP_INSERT, 32'sh8000_0000);
      send_item(bmhq_pkg::OP_INSERT, -32'sd1);
      send_item(bmhq_pkg::OP_INSERT, 32'sd5);
      send_item(bmhq_pkg::OP_INSERT, 32'sd5);
      send_item(bmhq_pkg::OP_INSERT, 32'sd5);
      send_item(bmhq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
      send_item(bmhq_pkg::OP_INSERT, 32'sd5);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sh7FFF_FFFF);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sh8000_0000);
      send_item(bmhq_pkg::OP_EXTRACT, -32'sd1);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sd0);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sd0);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sd0);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sd0);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sd0);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sd0);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sd0);
      send_item(bmhq_pkg::OP_EXTRACT, 32'sd0);

      // Random runs: fill-heavy runs push toward a full heap, drain-heavy runs toward empty.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         kind = $urandom_range(9);
         run_len = $urandom_range(10, 100);
         if (kind < 3)
            insert_pct = 90;
         else if (kind < 6)
            insert_pct = 10;
         else
            insert_pct = 50;
         for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
            if (sent == 400)
               drain_results();
            quiet = (sent >= 700 && sent < 1000);
            if (sent == 1200)
               hold_request = 1'b1;
            op = ($urandom_range(99) < insert_pct) ? bmhq_pkg::OP_INSERT
                                                   : bmhq_pkg::OP_EXTRACT;
            send_item(op, pick_value());
            sent++;
         end
      end

      drain_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("binary_max_heap_queue_top test passed");
      end else begin
         $display("binary_max_heap_queue_top test failed");
      end
      $finish;
   end

endmodule
